[hdl/cma_pkg.sv]
// package for the centered moving average block
// types, state codes and fixed widths shared by controller, datapath and top level
`default_nettype none
package cma_pkg;
    localparam int FIELD_BITS = 48;
    localparam int HW_BITS    = 3;
    localparam int ADDR_BITS  = 2;
    localparam int DATA_BITS  = 32;

    localparam logic [ADDR_BITS-1:0] ADDR_HALF_WIDTH = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SUM,
        ST_DRAIN,
        ST_DIVS,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_FULL,
        PH_TAIL
    } phase_t;

    typedef struct packed {
        logic push;
        logic clear;
        logic acc_clear;
        logic rd_en;
        logic time_rd;
        logic div_start;
        logic load_out;
        logic run_end;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } status_t;
endpackage
`default_nettype wire

[hdl/cma_if.sv]
// valid/ready channel interfaces for sample words and result words
// depends on cma_pkg for field widths
`default_nettype none
interface cma_in_if import cma_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] sample_value;
    logic [FIELD_BITS-1:0] sample_time;
    logic                  list_end;

    modport source (output valid, output sample_value, output sample_time, output list_end,
                    input ready);
    modport sink (input valid, input sample_value, input sample_time, input list_end,
                  output ready);
endinterface

interface cma_out_if import cma_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] average;
    logic [FIELD_BITS-1:0] center_time;
    logic                  run_end;

    modport source (output valid, output average, output center_time, output run_end,
                    input ready);
    modport sink (input valid, input average, input center_time, input run_end,
                  output ready);
endinterface
`default_nettype wire

[hdl/cma_ctrl.sv]
// controller: list tracking, result job sequencing and datapath commands
// depends on cma_pkg
`default_nettype none
module cma_ctrl
    import cma_pkg::*;
#(
    parameter int MAX_HALF   = 7,
    parameter int DEPTH      = 2 * MAX_HALF + 1,
    parameter int BACK_BITS  = $clog2(DEPTH),
    parameter int CNT_BITS   = $clog2(DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [HW_BITS-1:0]   half_width,
    input  wire logic                 cfg_clear,
    input  wire logic                 in_valid,
    input  wire logic                 in_last,
    output logic                      in_ready,
    input  wire status_t              status,
    output cmd_t                      cmd,
    output logic [BACK_BITS-1:0]      rd_back,
    output logic [BACK_BITS-1:0]      time_back,
    output logic [CNT_BITS-1:0]       div_count
);
    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [CNT_BITS-1:0]  seen_reg, seen_next;
    logic [BACK_BITS-1:0] k_reg, k_next;
    logic [BACK_BITS-1:0] back_reg, back_next;
    logic                 last_reg, last_next;

    logic [BACK_BITS-1:0] h, lo, hi, tb;
    logic [CNT_BITS-1:0]  w;
    logic                 job_end;

    always_comb
    begin
        if (half_width == '0)
            h = BACK_BITS'(1);
        else if (int'(half_width) > MAX_HALF)
            h = BACK_BITS'(MAX_HALF);
        else
            h = BACK_BITS'(half_width);
        w = CNT_BITS'(h) + CNT_BITS'(h) + CNT_BITS'(1);
    end

    always_comb
    begin
        case (phase_reg)
            PH_HEAD:
            begin
                lo      = h - k_reg;
                hi      = h + h;
                tb      = h + h - k_reg;
                job_end = (k_reg == h) && !last_reg;
            end
            PH_FULL:
            begin
                lo      = '0;
                hi      = h + h;
                tb      = h;
                job_end = !last_reg;
            end
            PH_TAIL:
            begin
                lo      = '0;
                hi      = k_reg + h;
                tb      = k_reg;
                job_end = (k_reg == '0);
            end
            default:
            begin
                lo      = '0;
                hi      = '0;
                tb      = '0;
                job_end = 1'b0;
            end
        endcase
    end

    assign rd_back   = back_reg;
    assign time_back = tb;
    assign div_count = CNT_BITS'(hi) - CNT_BITS'(lo) + CNT_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_FULL;
            seen_reg  <= '0;
            k_reg     <= '0;
            back_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            k_reg     <= k_next;
            back_reg  <= back_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        seen_next  = seen_reg;
        k_next     = k_reg;
        back_next  = back_reg;
        last_next  = last_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.push  = 1'b1;
                    last_next = in_last;
                    if (seen_reg < w)
                    begin
                        if (seen_reg + CNT_BITS'(1) == w)
                        begin
                            seen_next  = w;
                            phase_next = PH_HEAD;
                            k_next     = '0;
                            state_next = ST_START;
                        end
                        else if (in_last)
                        begin
                            cmd.clear = 1'b1;
                            seen_next = '0;
                        end
                        else
                        begin
                            seen_next = seen_reg + CNT_BITS'(1);
                        end
                    end
                    else
                    begin
                        phase_next = PH_FULL;
                        k_next     = '0;
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                cmd.acc_clear = 1'b1;
                back_next     = lo;
                state_next    = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.rd_en   = 1'b1;
                cmd.time_rd = 1'b1;
                if (back_reg == hi)
                    state_next = ST_DRAIN;
                else
                    back_next = back_reg + BACK_BITS'(1);
            end
            ST_DRAIN:
            begin
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.run_end  = job_end;
                    case (phase_reg)
                        PH_HEAD, PH_FULL:
                        begin
                            if (phase_reg == PH_HEAD && k_reg != h)
                            begin
                                k_next     = k_reg + BACK_BITS'(1);
                                state_next = ST_START;
                            end
                            else if (last_reg)
                            begin
                                phase_next = PH_TAIL;
                                k_next     = h - BACK_BITS'(1);
                                state_next = ST_START;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        default:
                        begin
                            if (k_reg == '0)
                            begin
                                cmd.clear  = 1'b1;
                                seen_next  = '0;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                k_next     = k_reg - BACK_BITS'(1);
                                state_next = ST_START;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_clear)
        begin
            cmd.clear = 1'b1;
            seen_next = '0;
        end
    end

    a_back_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |-> back_reg <= hi)
        else $error("read index ran past the window");
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= w)
        else $error("sample count beyond window");
    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> status.div_busy)
        else $error("divider did not start");
endmodule
`default_nettype wire

[hdl/cma_dp.sv]
// datapath: sample and time rings, window accumulator, restoring divider, output register
// depends on cma_pkg and cma_if
`default_nettype none
module cma_dp
    import cma_pkg::*;
#(
    parameter int MAX_HALF   = 7,
    parameter int VALUE_BITS = 48,
    parameter int DEPTH      = 2 * MAX_HALF + 1,
    parameter int BACK_BITS  = $clog2(DEPTH),
    parameter int CNT_BITS   = $clog2(DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    input  wire logic [BACK_BITS-1:0]  rd_back,
    input  wire logic [BACK_BITS-1:0]  time_back,
    input  wire logic [CNT_BITS-1:0]   div_count,
    input  wire logic [FIELD_BITS-1:0] sample_value,
    input  wire logic [FIELD_BITS-1:0] sample_time,
    output status_t                    status,
    cma_out_if.source                  result
);
    localparam int SUM_BITS  = VALUE_BITS + $clog2(DEPTH);
    localparam int STEP_BITS = $clog2(SUM_BITS + 1);

    logic [VALUE_BITS-1:0] value_ring [DEPTH];
    logic [FIELD_BITS-1:0] time_ring [DEPTH];

    logic [BACK_BITS-1:0]  head_reg;
    logic [VALUE_BITS-1:0] val_q_reg;
    logic                  acc_en_reg;
    logic [FIELD_BITS-1:0] time_q_reg;
    logic [SUM_BITS-1:0]   acc_reg;
    logic [SUM_BITS-1:0]   quo_reg;
    logic [CNT_BITS-1:0]   rem_reg;
    logic [CNT_BITS-1:0]   dsr_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic                  out_valid_reg;
    logic [FIELD_BITS-1:0] avg_reg;
    logic [FIELD_BITS-1:0] ctime_reg;
    logic                  run_end_reg;

    logic [CNT_BITS:0]     shifted;
    logic                  fits;

    function automatic logic [BACK_BITS-1:0] slot_of(input logic [BACK_BITS-1:0] head,
                                                     input logic [BACK_BITS-1:0] back);
        logic [BACK_BITS:0] t;
        t = {1'b0, head} + (BACK_BITS+1)'(DEPTH - 1) - {1'b0, back};
        if (t >= (BACK_BITS+1)'(DEPTH))
            t = t - (BACK_BITS+1)'(DEPTH);
        return t[BACK_BITS-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            value_ring[head_reg] <= VALUE_BITS'(sample_value);
            time_ring[head_reg]  <= sample_time;
        end
        if (cmd.rd_en)
            val_q_reg <= value_ring[slot_of(head_reg, rd_back)];
        if (cmd.time_rd)
            time_q_reg <= time_ring[slot_of(head_reg, time_back)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head_reg <= '0;
        else if (cmd.clear)
            head_reg <= '0;
        else if (cmd.push)
            head_reg <= (head_reg == BACK_BITS'(DEPTH - 1)) ? '0 : head_reg + BACK_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_en_reg <= 1'b0;
        else
            acc_en_reg <= cmd.rd_en;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clear)
            acc_reg <= '0;
        else if (acc_en_reg)
            acc_reg <= acc_reg + SUM_BITS'(val_q_reg);
    end

    assign shifted = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.div_start)
            step_reg <= STEP_BITS'(SUM_BITS);
        else if (step_reg != '0)
            step_reg <= step_reg - STEP_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= acc_reg;
            rem_reg <= '0;
            dsr_reg <= div_count;
        end
        else if (step_reg != '0)
        begin
            quo_reg <= {quo_reg[SUM_BITS-2:0], fits};
            rem_reg <= fits ? CNT_BITS'(shifted - {1'b0, dsr_reg}) : CNT_BITS'(shifted);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            avg_reg     <= FIELD_BITS'(quo_reg);
            ctime_reg   <= time_q_reg;
            run_end_reg <= cmd.run_end;
        end
    end

    assign status.div_busy    = (step_reg != '0);
    assign status.out_free    = !out_valid_reg || result.ready;
    assign result.valid       = out_valid_reg;
    assign result.average     = avg_reg;
    assign result.center_time = ctime_reg;
    assign result.run_end     = run_end_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || result.ready))
        else $error("result word overwritten");
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> step_reg == '0)
        else $error("divider restarted while busy");
    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> step_reg == '0)
        else $error("quotient taken before divide finished");
endmodule
`default_nettype wire

[hdl/centered_moving_average.sv]
// Centered moving average over 2h+1 samples with windows cut short at both list ends.
// Each sample word is taken only while the controller is idle; results follow one at a time,
// each summed from the sample ring one entry per cycle and then divided by an iterative
// restoring divider at one quotient bit per cycle. A sample that completes the first window
// releases h+1 results, a list end a further h. Writing half_width discards the list in
// progress.
// depends on cma_pkg, cma_if, cma_ctrl and cma_dp
`default_nettype none
module centered_moving_average
    import cma_pkg::*;
#(
    parameter int MAX_HALF   = 7,
    parameter int VALUE_BITS = 48
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0]      prdata,
    output logic                      pready,
    cma_in_if.sink                    sample_in,
    cma_out_if.source                 result_out
);
    localparam int DEPTH     = 2 * MAX_HALF + 1;
    localparam int BACK_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    logic [HW_BITS-1:0]   half_width_reg;
    logic                 cfg_write;
    cmd_t                 cmd;
    status_t              status;
    logic [BACK_BITS-1:0] rd_back;
    logic [BACK_BITS-1:0] time_back;
    logic [CNT_BITS-1:0]  div_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_HALF_WIDTH);
    assign prdata    = (paddr == ADDR_HALF_WIDTH) ? DATA_BITS'(half_width_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_width_reg <= HW_BITS'(1);
        else if (cfg_write)
            half_width_reg <= pwdata[HW_BITS-1:0];
    end

    cma_ctrl #(
        .MAX_HALF (MAX_HALF)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .half_width (half_width_reg),
        .cfg_clear  (cfg_write),
        .in_valid   (sample_in.valid),
        .in_last    (sample_in.list_end),
        .in_ready   (sample_in.ready),
        .status     (status),
        .cmd        (cmd),
        .rd_back    (rd_back),
        .time_back  (time_back),
        .div_count  (div_count)
    );

    cma_dp #(
        .MAX_HALF   (MAX_HALF),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_back      (rd_back),
        .time_back    (time_back),
        .div_count    (div_count),
        .sample_value (sample_in.sample_value),
        .sample_time  (sample_in.sample_time),
        .status       (status),
        .result       (result_out)
    );
endmodule
`default_nettype wire
